// ===== rtl/y2r_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and constants for the YUYV to RGB converter
// Payload structs, fixed-point coefficients and stage-to-stage bundles.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int PIX_W     = 8;   // one color or luma byte
  localparam int CHROMA_W  = 9;   // signed chroma offset, U-128 or V-128
  localparam int COEF_W    = 18;  // signed carrier for unsigned Q1.16 coefficients
  localparam int PROD_W    = CHROMA_W + COEF_W;
  localparam int TERM_W    = 25;  // chroma term, |term| < 2^24
  localparam int SUM_W     = 26;  // Y*2^16 plus chroma terms
  localparam int FRAC_BITS = 16;
  localparam int CLAMP_W   = SUM_W - FRAC_BITS;
  localparam int SCALE_SHIFT = 8;
  localparam int SCALE_W   = PIX_W + SCALE_SHIFT;

  // Coefficients times 65536, rounded to nearest
  localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd89831;   // 1.370705
  localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd45744;   // 0.698001
  localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22127;   // 0.337633
  localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd113538;  // 1.732446

  localparam logic [CLAMP_W-1:0] CHAN_MAX  = 10'd255;
  localparam logic [PIX_W-1:0]   SCALE_NUM = 8'd220;
  localparam logic [PIX_W-1:0]   OUT_MAX   = 8'd219;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
    logic             frame_end_in;
  } yuyv_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
    logic             frame_end_out;
  } rgb_t;

  // Stage 1 -> stage 2: chroma products and the lumas carried alongside
  typedef struct packed {
    logic [PIX_W-1:0]         luma_first;
    logic [PIX_W-1:0]         luma_second;
    logic signed [TERM_W-1:0] red_term;
    logic signed [TERM_W-1:0] green_v_term;
    logic signed [TERM_W-1:0] green_u_term;
    logic signed [TERM_W-1:0] blue_term;
    logic                     frame_end;
  } chroma_terms_t;

  // Stage 2 -> stage 3: full Q.16 sums per channel
  typedef struct packed {
    logic signed [SUM_W-1:0] red_first;
    logic signed [SUM_W-1:0] green_first;
    logic signed [SUM_W-1:0] blue_first;
    logic signed [SUM_W-1:0] red_second;
    logic signed [SUM_W-1:0] green_second;
    logic signed [SUM_W-1:0] blue_second;
    logic                    frame_end;
  } pixel_sums_t;

  // Handshake pair between neighboring stages
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_hs_t;

endpackage
`default_nettype wire

// ===== rtl/y2r_chroma_mult.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_chroma_mult: stage 1, chroma products
// Centers U and V and multiplies them by the four color coefficients.
// ----------------------------------------------------------------------------
module y2r_chroma_mult (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire y2r_pkg::yuyv_t up_data,
  output y2r_pkg::stage_hs_t  down_hs_valid,
  input  wire logic           down_ready,
  output y2r_pkg::chroma_terms_t down_data
);
  import y2r_pkg::*;

  logic                     valid;
  chroma_terms_t            terms;
  logic signed [CHROMA_W-1:0] du;
  logic signed [CHROMA_W-1:0] dv;
  logic signed [PROD_W-1:0] prod_rv;
  logic signed [PROD_W-1:0] prod_gv;
  logic signed [PROD_W-1:0] prod_gu;
  logic signed [PROD_W-1:0] prod_bu;

  // x - 128 for an unsigned byte: flip the top bit, sign-extend
  assign du = {~up_data.chroma_blue[PIX_W-1], ~up_data.chroma_blue[PIX_W-1],
               up_data.chroma_blue[PIX_W-2:0]};
  assign dv = {~up_data.chroma_red[PIX_W-1], ~up_data.chroma_red[PIX_W-1],
               up_data.chroma_red[PIX_W-2:0]};

  assign prod_rv = PROD_W'(dv) * PROD_W'(COEF_RV);
  assign prod_gv = PROD_W'(dv) * PROD_W'(COEF_GV);
  assign prod_gu = PROD_W'(du) * PROD_W'(COEF_GU);
  assign prod_bu = PROD_W'(du) * PROD_W'(COEF_BU);

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      terms.luma_first   <= up_data.luma_first;
      terms.luma_second  <= up_data.luma_second;
      terms.red_term     <= prod_rv[TERM_W-1:0];
      terms.green_v_term <= prod_gv[TERM_W-1:0];
      terms.green_u_term <= prod_gu[TERM_W-1:0];
      terms.blue_term    <= prod_bu[TERM_W-1:0];
      terms.frame_end    <= up_data.frame_end_in;
    end
  end

  assign down_hs_valid.valid = valid;
  assign down_hs_valid.ready = up_ready;
  assign down_data = terms;

endmodule
`default_nettype wire

// ===== rtl/y2r_luma_sum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_luma_sum: stage 2, channel sums
// For both pixels: luma at Q.16 plus red and blue terms, minus green terms.
// ----------------------------------------------------------------------------
module y2r_luma_sum (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire y2r_pkg::chroma_terms_t up_data,
  output logic                       down_valid,
  input  wire logic                  down_ready,
  output y2r_pkg::pixel_sums_t       down_data
);
  import y2r_pkg::*;

  logic                    valid;
  pixel_sums_t             sums;
  logic signed [SUM_W-1:0] base_first;
  logic signed [SUM_W-1:0] base_second;
  logic signed [SUM_W-1:0] red_ext;
  logic signed [SUM_W-1:0] green_ext;
  logic signed [SUM_W-1:0] blue_ext;

  assign base_first  = {{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, up_data.luma_first,
                        {FRAC_BITS{1'b0}}};
  assign base_second = {{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, up_data.luma_second,
                        {FRAC_BITS{1'b0}}};
  assign red_ext   = SUM_W'(up_data.red_term);
  assign green_ext = SUM_W'(up_data.green_v_term) + SUM_W'(up_data.green_u_term);
  assign blue_ext  = SUM_W'(up_data.blue_term);

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sums.red_first    <= base_first + red_ext;
      sums.green_first  <= base_first - green_ext;
      sums.blue_first   <= base_first + blue_ext;
      sums.red_second   <= base_second + red_ext;
      sums.green_second <= base_second - green_ext;
      sums.blue_second  <= base_second + blue_ext;
      sums.frame_end    <= up_data.frame_end;
    end
  end

  assign down_valid = valid;
  assign down_data  = sums;

endmodule
`default_nettype wire

// ===== rtl/y2r_clamp_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_clamp_scale: stage 3, clamp and scale, output register
// Truncates each sum to an integer, clamps to 0..255, scales by 220/256.
// ----------------------------------------------------------------------------
module y2r_clamp_scale (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire y2r_pkg::pixel_sums_t up_data,
  output logic                     down_valid,
  input  wire logic                down_ready,
  output y2r_pkg::rgb_t            down_data
);
  import y2r_pkg::*;

  logic valid;
  rgb_t rgb;

  function automatic logic [PIX_W-1:0] finish(input logic signed [SUM_W-1:0] s);
    logic [CLAMP_W-1:0] whole;
    logic [PIX_W-1:0]   c;
    logic [SCALE_W-1:0] scaled;
    whole = s[SUM_W-1:FRAC_BITS];
    if (s[SUM_W-1] || (s == '0)) begin
      c = '0;
    end else if (whole > CHAN_MAX) begin
      c = CHAN_MAX[PIX_W-1:0];
    end else begin
      c = whole[PIX_W-1:0];
    end
    scaled = SCALE_W'(c) * SCALE_W'(SCALE_NUM);
    return scaled[SCALE_W-1:SCALE_SHIFT];
  endfunction

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rgb.red_first     <= finish(up_data.red_first);
      rgb.green_first   <= finish(up_data.green_first);
      rgb.blue_first    <= finish(up_data.blue_first);
      rgb.red_second    <= finish(up_data.red_second);
      rgb.green_second  <= finish(up_data.green_second);
      rgb.blue_second   <= finish(up_data.blue_second);
      rgb.frame_end_out <= up_data.frame_end;
    end
  end

  assign down_valid = valid;
  assign down_data  = rgb;

endmodule
`default_nettype wire

// ===== rtl/yuyv_to_rgb_converter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter: YUYV 4:2:2 group to two scaled RGB888 pixels
// Three-stage pipeline: chroma multiply, luma sum, clamp and scale.
// ----------------------------------------------------------------------------
// Usage:
//   yuyv channel: one request carries one packed YUYV group (Y0, U, Y1, V)
//     plus a last-pair mark. A request is taken when yuyv_valid and
//     yuyv_ready are both high at a rising edge of clk.
//   rgb channel: one request carries both RGB pixels (each channel 0..219)
//     and the copied mark; it completes on rgb_valid and rgb_ready.
//   Path: a request is registered in the multiply, sum and output stages
//     in turn. Throughput: one group per cycle while rgb_ready is high,
//     set by the three fully pipelined stages, each with its own valid bit.
//   Stall: when rgb_ready is low, the output stage holds its request and
//     the earlier stages keep filling until each is occupied; empty stages
//     always accept, so bubbles are squeezed out. yuyv_ready drops only
//     once all three stages hold a request and the receiver still waits.
//   Reset: rst (synchronous, active high) drops every stage valid bit; no
//     request is in flight afterward. Payload registers are not reset.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           yuyv_valid,
  output logic                yuyv_ready,
  input  wire y2r_pkg::yuyv_t yuyv,
  output logic                rgb_valid,
  input  wire logic           rgb_ready,
  output y2r_pkg::rgb_t       rgb
);
  import y2r_pkg::*;

  stage_hs_t     mult_hs;
  chroma_terms_t mult_data;
  logic          sum_valid;
  logic          sum_ready;
  pixel_sums_t   sum_data;
  logic          scale_ready;

  // Stage 1: center chroma, form the four coefficient products
  y2r_chroma_mult u_mult (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (yuyv_valid),
    .up_ready      (yuyv_ready),
    .up_data       (yuyv),
    .down_hs_valid (mult_hs),
    .down_ready    (sum_ready),
    .down_data     (mult_data)
  );

  // Stage 2: add luma at Q.16 for each pixel and channel
  y2r_luma_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (mult_hs.valid),
    .up_ready   (sum_ready),
    .up_data    (mult_data),
    .down_valid (sum_valid),
    .down_ready (scale_ready),
    .down_data  (sum_data)
  );

  // Stage 3: truncate, clamp, scale by 220/256; this is the output register
  y2r_clamp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (sum_valid),
    .up_ready   (scale_ready),
    .up_data    (sum_data),
    .down_valid (rgb_valid),
    .down_ready (rgb_ready),
    .down_data  (rgb)
  );

  // A ready receiver frees every stage, so the input side must be open.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    rgb_ready |-> (yuyv_ready && mult_hs.ready))
    else $error("input stalled while the receiver is ready");

  // Scaling bounds every channel to 219.
  a_range_first: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> (rgb.red_first <= OUT_MAX && rgb.green_first <= OUT_MAX &&
                   rgb.blue_first <= OUT_MAX))
    else $error("first pixel channel above scaled maximum");

  a_range_second: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> (rgb.red_second <= OUT_MAX && rgb.green_second <= OUT_MAX &&
                   rgb.blue_second <= OUT_MAX))
    else $error("second pixel channel above scaled maximum");

  // With the receiver open, a request passes the multiply, sum and output
  // stages in turn and carries its frame mark along.
  a_latency_mark: assert property (@(posedge clk) disable iff (rst)
    (yuyv_valid && yuyv_ready) ##1 rgb_ready ##1 rgb_ready
      |=> (rgb_valid && (rgb.frame_end_out == $past(yuyv.frame_end_in, 3))))
    else $error("request lost or frame mark corrupted in pipeline");

endmodule
`default_nettype wire

// ===== tb/yuyv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_tb: self-checking bench for the YUYV to RGB converter
// Pushes directed corner groups and then random frames through the yuyv
// channel with random sender gaps and receiver stalls. A Q.16 color matrix
// built into the bench predicts both pixels of every accepted group, and each
// rgb request is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_tb;
  import y2r_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 10;
  localparam int DIRECTED_GROUPS = 16;
  localparam int RANDOM_GROUPS   = 1934;
  localparam int SETTLE_CYCLES   = 8;     // pipeline is 3 deep, leave margin
  localparam int MAX_FRAME       = 64;

  // Color matrix gains in Q.16, chroma midpoint and output trim
  localparam int RED_V_GAIN   = 89831;
  localparam int GREEN_V_GAIN = 45744;
  localparam int GREEN_U_GAIN = 22127;
  localparam int BLUE_U_GAIN  = 113538;
  localparam int CHROMA_ZERO  = 128;
  localparam int LEVEL_CAP    = 255;
  localparam int TRIM_NUM     = 220;
  localparam int TRIM_SHIFT   = 8;
  localparam int Q_BITS       = 16;

  // One group waiting to be sent: payload, idle cycles ahead of it, and
  // whether the sender must first wait for every outstanding result
  typedef struct {
    yuyv_t       grp;
    int unsigned gap;
    bit          drain;
  } queued_group_t;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  yuyv_valid = 1'b0;
  logic  yuyv_ready;
  yuyv_t yuyv       = '0;
  logic  rgb_valid;
  logic  rgb_ready  = 1'b0;
  rgb_t  rgb;

  queued_group_t group_queue[$];
  rgb_t          rgb_due[$];        // predicted pixel pairs, oldest first
  int unsigned   groups_queued = 0;
  int unsigned   groups_taken  = 0;
  int unsigned   error_count   = 0;
  logic          group_taken   = 1'b0;  // yuyv request accepted at last rise
  logic          pixels_taken  = 1'b0;  // rgb request accepted at last rise
  int unsigned   stall_left    = 0;
  bit            rx_calm       = 1'b0;

  yuyv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .yuyv_valid (yuyv_valid),
    .yuyv_ready (yuyv_ready),
    .yuyv       (yuyv),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .rgb        (rgb)
  );

  always #HALF_PERIOD clk = ~clk;

  // Truncate a Q.16 sum toward zero, clamp to 0..255, then trim by 220/256
  function automatic logic [7:0] trim_level(int sum);
    int level;
    if (sum <= 0) return 8'd0;
    level = sum >>> Q_BITS;
    if (level > LEVEL_CAP) level = LEVEL_CAP;
    return 8'((level * TRIM_NUM) >> TRIM_SHIFT);
  endfunction

  // Expected pixel pair for one YUYV group
  function automatic rgb_t convert_group(yuyv_t g);
    int   du;
    int   dv;
    int   y0;
    int   y1;
    rgb_t px;
    du = int'(g.chroma_blue) - CHROMA_ZERO;
    dv = int'(g.chroma_red) - CHROMA_ZERO;
    y0 = int'(g.luma_first) << Q_BITS;
    y1 = int'(g.luma_second) << Q_BITS;
    px.red_first     = trim_level(y0 + RED_V_GAIN * dv);
    px.green_first   = trim_level(y0 - GREEN_V_GAIN * dv - GREEN_U_GAIN * du);
    px.blue_first    = trim_level(y0 + BLUE_U_GAIN * du);
    px.red_second    = trim_level(y1 + RED_V_GAIN * dv);
    px.green_second  = trim_level(y1 - GREEN_V_GAIN * dv - GREEN_U_GAIN * du);
    px.blue_second   = trim_level(y1 + BLUE_U_GAIN * du);
    px.frame_end_out = g.frame_end_in;
    return px;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic add_group(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                           logic [7:0] v, logic fe, int unsigned gap, bit drain);
    queued_group_t q;
    q.grp.luma_first   = y0;
    q.grp.chroma_blue  = u;
    q.grp.luma_second  = y1;
    q.grp.chroma_red   = v;
    q.grp.frame_end_in = fe;
    q.gap              = gap;
    q.drain            = drain;
    group_queue.push_back(q);
    groups_queued++;
  endtask

  // Favor the rails and the chroma midpoint, otherwise any byte
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(CHROMA_ZERO - 3 + $urandom_range(0, 6));
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned frame_len;
    bit          calm;
    bit          first_frame;

    // Directed corners: rails, neutral chroma, saturation both ways on every
    // channel, negative and sub-unit fractions, alternating bit patterns
    add_group(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 0, 1'b0);
    add_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0, 1'b0);
    add_group(8'd0,   8'd128, 8'd255, 8'd128, 1'b0, 0, 1'b0);
    add_group(8'd128, 8'd128, 8'd1,   8'd128, 1'b1, 0, 1'b0);
    add_group(8'd255, 8'd255, 8'd0,   8'd128, 1'b0, 1, 1'b0);  // blue overshoot
    add_group(8'd0,   8'd0,   8'd255, 8'd128, 1'b1, 0, 1'b0);  // blue undershoot
    add_group(8'd255, 8'd128, 8'd0,   8'd255, 1'b0, 2, 1'b0);  // red overshoot
    add_group(8'd0,   8'd128, 8'd255, 8'd0,   1'b1, 0, 1'b0);  // red undershoot
    add_group(8'd0,   8'd255, 8'd0,   8'd255, 1'b0, 3, 1'b0);  // green below black
    add_group(8'd255, 8'd0,   8'd255, 8'd0,   1'b1, 0, 1'b0);  // green above white
    add_group(8'd1,   8'd128, 8'd2,   8'd127, 1'b0, 0, 1'b0);  // negative fraction
    add_group(8'd0,   8'd128, 8'd0,   8'd129, 1'b1, 7, 1'b0);  // red just above one
    add_group(8'd0,   8'd127, 8'd0,   8'd128, 1'b0, 0, 1'b0);  // green below one
    add_group(8'd170, 8'd85,  8'd85,  8'd170, 1'b1, 0, 1'b0);
    add_group(8'd85,  8'd170, 8'd170, 8'd85,  1'b0, 4, 1'b0);
    add_group(8'd16,  8'd128, 8'd235, 8'd128, 1'b1, 0, 1'b0);

    // Random frames; some run back to back, some open after a full drain
    while (groups_queued < DIRECTED_GROUPS + RANDOM_GROUPS) begin
      frame_len   = $urandom_range(1, MAX_FRAME);
      calm        = ($urandom_range(0, 3) == 0);
      first_frame = (groups_queued == DIRECTED_GROUPS);
      for (int unsigned i = 0; i < frame_len; i++)
        add_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  i == frame_len - 1, calm ? 0 : $urandom_range(0, 7),
                  i == 0 && (first_frame || $urandom_range(0, 15) == 0));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every group to be taken and every pixel pair to come back
    while (groups_taken < groups_queued || rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("yuyv_to_rgb_converter_tb: clean");
    else
      $display("yuyv_to_rgb_converter_tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("yuyv_to_rgb_converter_tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: present one queued group at a time on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      yuyv_valid <= 1'b0;
    end else if (yuyv_valid && !group_taken) begin
      // hold the request and its payload until accepted
    end else if (group_queue.size() == 0) begin
      yuyv_valid <= 1'b0;
    end else if (group_queue[0].drain) begin
      // pause until the pipeline has handed back every result
      yuyv_valid <= 1'b0;
      if (rgb_due.size() == 0) group_queue[0].drain = 1'b0;
    end else if (group_queue[0].gap != 0) begin
      yuyv_valid <= 1'b0;
      group_queue[0].gap--;
    end else begin
      yuyv_valid <= 1'b1;
      yuyv       <= group_queue.pop_front().grp;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall a random count after each result, sometimes never
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rgb_ready <= 1'b0;
    end else begin
      if (pixels_taken) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 7);
      end
      if (stall_left != 0) begin
        rgb_ready <= 1'b0;
        stall_left--;
      end else begin
        rgb_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted group, check each accepted pixel pair
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      group_taken  <= 1'b0;
      pixels_taken <= 1'b0;
    end else begin
      group_taken  <= yuyv_valid && yuyv_ready;
      pixels_taken <= rgb_valid && rgb_ready;
      if (yuyv_valid && yuyv_ready) begin
        rgb_due.push_back(convert_group(yuyv));
        groups_taken++;
      end
      if (rgb_valid && rgb_ready) begin
        if (rgb_due.size() == 0) begin
          $error("rgb request with no YUYV group outstanding");
          error_count++;
        end else begin
          want = rgb_due.pop_front();
          check_field("red_first",     want.red_first,     rgb.red_first);
          check_field("green_first",   want.green_first,   rgb.green_first);
          check_field("blue_first",    want.blue_first,    rgb.blue_first);
          check_field("red_second",    want.red_second,    rgb.red_second);
          check_field("green_second",  want.green_second,  rgb.green_second);
          check_field("blue_second",   want.blue_second,   rgb.blue_second);
          check_field("frame_end_out", want.frame_end_out, rgb.frame_end_out);
        end
      end
    end
  end

endmodule

// ===== yuyv_to_rgb_converter.f =====
rtl/y2r_pkg.sv
rtl/y2r_chroma_mult.sv
rtl/y2r_luma_sum.sv
rtl/y2r_clamp_scale.sv
rtl/yuyv_to_rgb_converter.sv
tb/yuyv_to_rgb_converter_tb.sv
